/* rtl/kpr_pkg.sv */
// ----------------------------------------------------------------------------
// kpr_pkg
// Shared types and constants for the palette refiner.
// ----------------------------------------------------------------------------
package kpr_pkg;
  localparam int PALETTE_SIZE = 16;
  localparam int COUNT_BITS   = 24;
  localparam int IDX_BITS     = $clog2(PALETTE_SIZE);
  localparam int SUM_BITS     = 32;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [4:0] PCOUNT_RESET = 5'd10;
  localparam logic [7:0] TOL_RESET    = 8'd2;

  localparam logic REG_PCOUNT = 1'b0;
  localparam logic REG_TOL    = 1'b1;

  // Entry handed from the front to the back.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_PIX, ST_DIV, ST_EMIT
  } state_t;
endpackage

/* rtl/kpr_front.sv */
// ----------------------------------------------------------------------------
// kpr_front
// Input acceptance and a short queue of items toward the back end.
// ----------------------------------------------------------------------------
module kpr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  kpr_pkg::item_t  in_item,
  output logic            q_valid,
  input  logic            q_pop,
  output kpr_pkg::item_t  q_item
);
  import kpr_pkg::*;

  item_t               mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QPTR_BITS:0]   fill;
  logic                 push;
  logic                 drop;

  // kind 3 is dropped here; it causes nothing
  assign drop    = (in_item.kind != KIND_LOAD) && (in_item.kind != KIND_PIXEL) &&
                   (in_item.kind != KIND_END);
  assign ready   = (fill != (QPTR_BITS+1)'(QDEPTH));
  assign push    = valid && ready && !drop;
  assign q_valid = (fill != '0);
  assign q_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      fill <= fill + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);
    end
  end
endmodule

/* rtl/kpr_divider.sv */
// ----------------------------------------------------------------------------
// kpr_divider
// Restoring divider, one quotient bit per cycle, quotient clamped to 255.
// ----------------------------------------------------------------------------
module kpr_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kpr_pkg::SUM_BITS-1:0]   dividend,
  input  logic [kpr_pkg::COUNT_BITS-1:0] divisor,
  output logic                         done,
  output logic [7:0]                   quot
);
  import kpr_pkg::*;

  localparam int CBITS = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0]   q;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [CBITS-1:0]      cnt;
  logic                  busy;
  logic [COUNT_BITS:0]   trial;

  assign trial = {rem[COUNT_BITS-1:0], q[SUM_BITS-1]};
  assign quot  = (q > SUM_BITS'(255)) ? 8'd255 : q[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CBITS'(SUM_BITS);
        q    <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift one dividend bit into the remainder
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          q   <= {q[SUM_BITS-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[SUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CBITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/kpr_back.sv */
// ----------------------------------------------------------------------------
// kpr_back
// Palette search, accumulation and end-of-pass update sequencer.
// ----------------------------------------------------------------------------
module kpr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  kpr_pkg::item_t  q_item,
  input  logic [4:0]      palette_count,
  input  logic [7:0]      tolerance,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      result_index,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out,
  output logic            converged,
  output logic            overflow,
  output logic            last
);
  import kpr_pkg::*;

  logic [23:0]           pal  [PALETTE_SIZE];
  logic [SUM_BITS-1:0]   sums [PALETTE_SIZE][3];
  logic [COUNT_BITS-1:0] cnts [PALETTE_SIZE];
  logic                  ovf_seen;

  state_t                state, state_next;
  logic [IDX_BITS-1:0]   ptr;
  logic [IDX_BITS-1:0]   best;
  logic [9:0]            bestd;
  logic [IDX_BITS:0]     nact;
  logic [1:0]            ch;
  logic                  conv;
  logic [7:0]            nv [3];
  item_t                 cur;

  logic                  div_start, div_done, div_busy;
  logic [7:0]            div_q;
  logic [SUM_BITS-1:0]   div_a;

  // active entry count, clamped
  always_comb begin
    priority if (palette_count == 5'd0) nact = (IDX_BITS+1)'(1);
    else if (32'(palette_count) > PALETTE_SIZE) nact = (IDX_BITS+1)'(PALETTE_SIZE);
    else nact = (IDX_BITS+1)'(palette_count);
  end

  // distance from current pixel to entry at ptr
  logic [9:0] pix_dist;
  logic [7:0] pr, pg, pb;
  assign pr = pal[ptr][23:16];
  assign pg = pal[ptr][15:8];
  assign pb = pal[ptr][7:0];
  always_comb begin
    pix_dist = 10'((cur.red   > pr) ? cur.red   - pr : pr - cur.red)
             + 10'((cur.green > pg) ? cur.green - pg : pg - cur.green)
             + 10'((cur.blue  > pb) ? cur.blue  - pb : pb - cur.blue);
  end

  logic last_ptr;
  assign last_ptr = ({1'b0, ptr} + (IDX_BITS+1)'(1)) == nact;

  // saturation check for the chosen entry
  logic sat;
  always_comb begin
    sat = (cnts[best] == {COUNT_BITS{1'b1}})
       || ({1'b0, sums[best][0]} + (SUM_BITS+1)'(cur.red)) > {1'b0, {SUM_BITS{1'b1}}}
       || ({1'b0, sums[best][1]} + (SUM_BITS+1)'(cur.green)) > {1'b0, {SUM_BITS{1'b1}}}
       || ({1'b0, sums[best][2]} + (SUM_BITS+1)'(cur.blue)) > {1'b0, {SUM_BITS{1'b1}}};
  end

  logic empty_c;
  assign empty_c = (cnts[ptr] == '0);
  logic [7:0] oldc;
  always_comb begin
    unique case (ch)
      2'd0:    oldc = pr;
      2'd1:    oldc = pg;
      default: oldc = pb;
    endcase
  end
  logic [7:0] cdiff;
  assign cdiff = (div_q > oldc) ? div_q - oldc : oldc - div_q;

  // kick one channel divide when the entry has pixels and no divide is running
  assign div_start = (state == ST_DIV) && !empty_c && !div_busy;
  assign div_a     = sums[ptr][ch];

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_item.kind == KIND_PIXEL) state_next = ST_SCAN;
        else if (q_item.kind == KIND_END) state_next = ST_DIV;
      end
      ST_SCAN: if (last_ptr) state_next = ST_PIX;
      ST_PIX:  state_next = ST_EMIT;
      ST_DIV: begin
        if (empty_c) state_next = ST_EMIT;
        else if (div_busy && div_done && ch == 2'd2) state_next = ST_EMIT;
      end
      ST_EMIT: if (out_ready) begin
        if (cur.kind == KIND_PIXEL || last) state_next = ST_IDLE;
        else state_next = ST_DIV;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  kpr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_a), .divisor(cnts[ptr]), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_valid <= 1'b0;
      ovf_seen <= 1'b0;
      div_busy <= 1'b0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
        pal[i]  <= '0;
        cnts[i] <= '0;
        for (int c = 0; c < 3; c++) sums[i][c] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (q_valid) begin
          cur   <= q_item;
          ptr   <= '0;
          best  <= '0;
          bestd <= '1;
          ch    <= '0;
          conv  <= 1'b1;
          div_busy <= 1'b0;
          if (q_item.kind == KIND_LOAD &&
              32'(q_item.entry_index) < PALETTE_SIZE)
            pal[q_item.entry_index[IDX_BITS-1:0]] <=
              {q_item.red, q_item.green, q_item.blue};
        end
        ST_SCAN: begin
          if (pix_dist < bestd) begin
            bestd <= pix_dist;
            best  <= ptr;
          end
          if (!last_ptr) ptr <= ptr + 1'b1;
        end
        ST_PIX: begin
          if (sat) ovf_seen <= 1'b1;
          else begin
            cnts[best]    <= cnts[best] + 1'b1;
            sums[best][0] <= sums[best][0] + SUM_BITS'(cur.red);
            sums[best][1] <= sums[best][1] + SUM_BITS'(cur.green);
            sums[best][2] <= sums[best][2] + SUM_BITS'(cur.blue);
          end
          result_index <= 4'(best);
          {red_out, green_out, blue_out} <= pal[best];
          converged <= 1'b0;
          overflow  <= ovf_seen | sat;
          last      <= 1'b1;
          out_valid <= 1'b1;
        end
        ST_DIV: begin
          if (empty_c) begin
            result_index <= 4'(ptr);
            {red_out, green_out, blue_out} <= pal[ptr];
            converged <= last_ptr & conv;
            overflow  <= ovf_seen;
            last      <= last_ptr;
            out_valid <= 1'b1;
          end else if (!div_busy) begin
            div_busy <= 1'b1;
          end else if (div_done) begin
            div_busy <= 1'b0;
            nv[ch] <= div_q;
            if (cdiff > tolerance) conv <= 1'b0;
            if (ch == 2'd2) begin
              pal[ptr] <= {nv[0], nv[1], div_q};
              result_index <= 4'(ptr);
              {red_out, green_out, blue_out} <= {nv[0], nv[1], div_q};
              converged <= last_ptr & conv & !(cdiff > tolerance);
              overflow  <= ovf_seen;
              last      <= last_ptr;
              out_valid <= 1'b1;
              ch        <= '0;
            end else ch <= ch + 1'b1;
          end
        end
        ST_EMIT: if (out_ready) begin
          out_valid <= 1'b0;
          if (cur.kind == KIND_END) begin
            if (last) begin
              ovf_seen <= 1'b0;
              for (int i = 0; i < PALETTE_SIZE; i++) begin
                cnts[i] <= '0;
                for (int c = 0; c < 3; c++) sums[i][c] <= '0;
              end
            end else ptr <= ptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/kmeans_palette_refiner_unit.sv */
// ----------------------------------------------------------------------------
// kmeans_palette_refiner_unit
// K-means palette refinement with L1 distance, APB configuration.
// ----------------------------------------------------------------------------
// Pixel: queue pop, entry scan loop over the active entries, accumulate, result;
// the next item is popped only after the result is taken. End of pass: three
// channel divides per non-empty entry, none for an empty one. Load: palette write.
// Input queue of four beats decouples intake from the back end.
// Reset (synchronous): palette and accumulators cleared, count 10, tolerance 2.
module kmeans_palette_refiner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  entry_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  result_index,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        converged,
  output logic        overflow,
  output logic        last
);
  import kpr_pkg::*;

  logic [4:0] palette_count;
  logic [7:0] tolerance;
  item_t      in_item, q_item;
  logic       q_valid, q_pop;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= PCOUNT_RESET;
      tolerance     <= TOL_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == 1'b0) begin
      if (paddr[2] == REG_PCOUNT) palette_count <= pwdata[4:0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TOL) tolerance <= pwdata[7:0];
    end
  end

  always_comb begin
    priority if (paddr[2] == REG_PCOUNT) prdata = {27'd0, palette_count};
    else prdata = {24'd0, tolerance};
  end

  assign in_item = '{kind: kind, entry_index: entry_index, red: red,
                     green: green, blue: blue};

  kpr_front u_front (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .in_item(in_item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  kpr_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .palette_count(palette_count), .tolerance(tolerance),
    .out_valid(out_valid), .out_ready(out_ready), .result_index(result_index),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .converged(converged), .overflow(overflow), .last(last)
  );
endmodule

/* rtl/kpr_checker.sv */
// ----------------------------------------------------------------------------
// kpr_checker
// Port-level checks for the palette refiner.
// ----------------------------------------------------------------------------
module kpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] result_index,
  input logic       converged,
  input logic       last,
  input logic       pready
);
  // converged only shows on a final beat
  a_conv_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> last) else $error("converged without last");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_index))
    else $error("result dropped under stall");

  // config port never stalls
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind kmeans_palette_refiner_unit kpr_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .result_index(result_index), .converged(converged), .last(last), .pready(pready)
);

/* sim/kmeans_palette_refiner_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_palette_refiner_unit_test
// Streams palette loads, pixels and end-of-pass beats into the refiner and
// checks every result beat against a cycle-free palette model kept here.
// Configuration goes through the APB port between phases.
// ----------------------------------------------------------------------------
module kmeans_palette_refiner_unit_test;
  import kpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] idx;
    logic [7:0] r, g, b;
  } pixel_beat_t;

  typedef struct {
    logic [3:0] idx;
    logic [7:0] r, g, b;
    logic       conv, ovf, lst;
  } palette_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        valid = 1'b0;
  logic        ready;
  logic [1:0]  kind = '0;
  logic [3:0]  entry_index = '0;
  logic [7:0]  red = '0, green = '0, blue = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  result_index;
  logic [7:0]  red_out, green_out, blue_out;
  logic        converged, overflow, last;

  kmeans_palette_refiner_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  logic [7:0]  pal_r [PALETTE_SIZE], pal_g [PALETTE_SIZE], pal_b [PALETTE_SIZE];
  logic [31:0] sum_r [PALETTE_SIZE], sum_g [PALETTE_SIZE], sum_b [PALETTE_SIZE];
  logic [COUNT_BITS-1:0] pix_count [PALETTE_SIZE];
  logic        ovf_seen;
  logic [4:0]  pcount_cfg = PCOUNT_RESET;
  logic [7:0]  tol_cfg = TOL_RESET;

  pixel_beat_t  pending_q[$];
  palette_res_t expected_q[$];
  pixel_beat_t  cur_beat;
  int           errors = 0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           hold_left = 0;
  bit           hold_req = 0;
  bit           quiet = 0;

  function automatic int active_entries();
    if (pcount_cfg == 0) return 1;
    if (pcount_cfg > PALETTE_SIZE) return PALETTE_SIZE;
    return int'(pcount_cfg);
  endfunction

  function automatic logic [8:0] absd(logic [7:0] a, logic [7:0] b);
    return (a > b) ? 9'(a - b) : 9'(b - a);
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      sum_r[i] = '0; sum_g[i] = '0; sum_b[i] = '0; pix_count[i] = '0;
    end
    ovf_seen = 1'b0;
  endfunction

  // Expected results of one accepted beat
  function automatic void refine_predict(pixel_beat_t t);
    int n;
    int best;
    int bestd;
    int d;
    bit conv;
    logic [31:0] nv [3];
    palette_res_t e;
    n = active_entries();
    case (t.kind)
      KIND_LOAD: begin
        pal_r[t.idx] = t.r; pal_g[t.idx] = t.g; pal_b[t.idx] = t.b;
      end
      KIND_PIXEL: begin
        best = 0;
        bestd = 32'h7fffffff;
        for (int i = 0; i < n; i++) begin
          d = int'(absd(t.r, pal_r[i])) + int'(absd(t.g, pal_g[i]))
            + int'(absd(t.b, pal_b[i]));
          if (d < bestd) begin
            bestd = d; best = i;
          end
        end
        if (&pix_count[best] || {1'b0, sum_r[best]} + 33'(t.r) > 33'hffffffff ||
            {1'b0, sum_g[best]} + 33'(t.g) > 33'hffffffff ||
            {1'b0, sum_b[best]} + 33'(t.b) > 33'hffffffff) begin
          ovf_seen = 1'b1;
        end else begin
          pix_count[best]++;
          sum_r[best] += 32'(t.r); sum_g[best] += 32'(t.g); sum_b[best] += 32'(t.b);
        end
        e = '{best[3:0], pal_r[best], pal_g[best], pal_b[best], 1'b0, ovf_seen, 1'b1};
        expected_q.insert(expected_q.size(), e);
      end
      KIND_END: begin
        conv = 1;
        for (int i = 0; i < n; i++) begin
          if (pix_count[i] != 0) begin
            nv[0] = sum_r[i] / 32'(pix_count[i]);
            nv[1] = sum_g[i] / 32'(pix_count[i]);
            nv[2] = sum_b[i] / 32'(pix_count[i]);
            for (int c = 0; c < 3; c++) if (nv[c] > 255) nv[c] = 32'd255;
            if (absd(nv[0][7:0], pal_r[i]) > 9'(tol_cfg)) conv = 0;
            if (absd(nv[1][7:0], pal_g[i]) > 9'(tol_cfg)) conv = 0;
            if (absd(nv[2][7:0], pal_b[i]) > 9'(tol_cfg)) conv = 0;
            pal_r[i] = nv[0][7:0]; pal_g[i] = nv[1][7:0]; pal_b[i] = nv[2][7:0];
          end
          e = '{i[3:0], pal_r[i], pal_g[i], pal_b[i], (i == n - 1) && conv,
                ovf_seen, i == n - 1};
          expected_q.insert(expected_q.size(), e);
        end
        clear_sums();
      end
      default: ;
    endcase
  endfunction

  // Driver: one beat in flight, random gaps between beats
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && ready) refine_predict(cur_beat);
      if (valid && !ready) begin
        valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_beat = pending_q.pop_front();
        kind <= cur_beat.kind;
        entry_index <= cur_beat.idx;
        red <= cur_beat.r; green <= cur_beat.g; blue <= cur_beat.b;
        valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = int'($urandom_range(1, 16));
      end else begin
        valid <= 1'b0;
      end
    end
  end

  // Monitor: compare result beats, random and long stalls
  always @(posedge clk) begin
    palette_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat idx=%0d", $time, result_index);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result_index !== e.idx) begin
            $display("%0t: result_index exp %0d got %0d", $time, e.idx, result_index);
            errors++;
          end
          if (red_out !== e.r) begin
            $display("%0t: red_out exp %0d got %0d", $time, e.r, red_out);
            errors++;
          end
          if (green_out !== e.g) begin
            $display("%0t: green_out exp %0d got %0d", $time, e.g, green_out);
            errors++;
          end
          if (blue_out !== e.b) begin
            $display("%0t: blue_out exp %0d got %0d", $time, e.b, blue_out);
            errors++;
          end
          if (converged !== e.conv) begin
            $display("%0t: converged exp %0b got %0b", $time, e.conv, converged);
            errors++;
          end
          if (overflow !== e.ovf) begin
            $display("%0t: overflow exp %0b got %0b", $time, e.ovf, overflow);
            errors++;
          end
          if (last !== e.lst) begin
            $display("%0t: last exp %0b got %0b", $time, e.lst, last);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = int'($urandom_range(0, 15));
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((valid && ready) || (out_valid && out_ready) || psel || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("kmeans_palette_refiner_unit_test failed");
      $finish;
    end
  end

  task automatic cfg_write(logic addr_sel, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {addr_sel, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr_sel == REG_PCOUNT) pcount_cfg = data[4:0];
    else tol_cfg = data[7:0];
  endtask

  task automatic send(logic [1:0] k, logic [3:0] i, logic [7:0] r, g, b);
    pixel_beat_t t;
    t = '{k, i, r, g, b};
    pending_q.insert(pending_q.size(), t);
  endtask

  // Hold off until every beat is in and every result is out
  task automatic drain();
    while (pending_q.size() > 0 || valid || expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_near_pixel(int n);
    int e;
    e = int'($urandom_range(0, n - 1));
    send(KIND_PIXEL, 4'($urandom()), 8'(pal_r[e] ^ 8'($urandom_range(0, 15))),
         8'(pal_g[e] ^ 8'($urandom_range(0, 15))),
         8'(pal_b[e] ^ 8'($urandom_range(0, 15))));
  endtask

  initial begin
    int sent;
    int n;
    int np;
    int nl;
    bit held;
    pixel_beat_t pass_pix[$];
    held = 0;
    clear_sums();
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      pal_r[i] = '0; pal_g[i] = '0; pal_b[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: full palette, zero tolerance, extremes, tie, unused kind
    cfg_write(REG_PCOUNT, 32'd16);
    cfg_write(REG_TOL, 32'd0);
    for (int i = 0; i < 15; i++) send(KIND_LOAD, 4'(i), 8'(i * 17), 8'(255 - i * 17), 8'(i * 8));
    send(KIND_LOAD, 4'd15, 8'hff, 8'hff, 8'hff);
    send(KIND_LOAD, 4'd1, 8'd20, 8'd255, 8'd0);
    send(KIND_PIXEL, 4'd0, 8'h00, 8'hff, 8'h00);
    send(KIND_PIXEL, 4'hf, 8'hff, 8'hff, 8'hff);
    send(KIND_PIXEL, 4'd0, 8'd10, 8'd255, 8'd0);
    send(KIND_PIXEL, 4'd0, 8'h00, 8'h00, 8'h00);
    send(KIND_UNUSED, 4'ha, 8'h55, 8'haa, 8'h5a);
    send(KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    drain();
    // palette count zero acts as one; max tolerance
    cfg_write(REG_PCOUNT, 32'd0);
    cfg_write(REG_TOL, 32'd255);
    send(KIND_PIXEL, 4'd0, 8'h80, 8'h01, 8'hfe);
    send(KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    drain();
    // above sixteen clamps
    cfg_write(REG_PCOUNT, 32'd31);
    send(KIND_PIXEL, 4'd0, 8'h7f, 8'h7f, 8'h7f);
    send(KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
    drain();

    // Random passes: loads, clustered pixels, end; sometimes replayed
    sent = 0;
    while (sent < 150) begin
      if (sent > 120) quiet = 1;
      cfg_write(REG_PCOUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(2, 16));
      cfg_write(REG_TOL, ($urandom_range(0, 1)) ? $urandom_range(0, 8)
                                                : $urandom_range(0, 255));
      n = active_entries();
      nl = int'($urandom_range(0, 4));
      for (int i = 0; i < nl; i++) begin
        send(KIND_LOAD, 4'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        sent++;
      end
      drain();
      // one long receiver hold while the pass streams in
      if (sent > 40 && !held) begin
        hold_req = 1;
        held = 1;
      end
      np = int'($urandom_range(6, 16));
      pass_pix.delete();
      for (int i = 0; i < np; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send(2'($urandom_range(0, 3)), 4'($urandom()), 8'($urandom()), 8'($urandom()),
               8'($urandom()));
        end else if ($urandom_range(0, 3) == 0) begin
          send(KIND_PIXEL, 4'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        end else begin
          send_near_pixel(n);
        end
        pass_pix.insert(pass_pix.size(), pending_q[$]);
        sent++;
      end
      send(KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
      sent++;
      if ($urandom_range(0, 2) == 0) begin
        drain();
        foreach (pass_pix[i]) pending_q.insert(pending_q.size(), pass_pix[i]);
        send(KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
        sent += pass_pix.size() + 1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("kmeans_palette_refiner_unit_test passed");
    end else begin
      $display("kmeans_palette_refiner_unit_test failed");
    end
    $finish;
  end
endmodule

/* kmeans_palette_refiner_unit.f */
rtl/kpr_pkg.sv
rtl/kpr_front.sv
rtl/kpr_divider.sv
rtl/kpr_back.sv
rtl/kmeans_palette_refiner_unit.sv
rtl/kpr_checker.sv
sim/kmeans_palette_refiner_unit_test.sv
